// ===== sv/fsmt_pkg.sv =====
// shared constants, codes and control types for the framed spi transceiver
package fsmt_pkg;

  localparam int RX_DEPTH_DEF = 16;
  localparam int TX_DEPTH_DEF = 64;
  // arithmetic width for frame length math, holds TX_DEPTH + 2 at its maximum
  localparam int SUM_W        = 8;
  localparam int RX_CNT_W     = 4;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_XCHG  = 2'd2;

  localparam logic [1:0] KIND_MOSI   = 2'd0;
  localparam logic [1:0] KIND_RX     = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_AMP = 8'h26;

  typedef enum logic [5:0] {
    ST_WAIT     = 6'b000001,
    ST_FETCH    = 6'b000010,
    ST_EMIT     = 6'b000100,
    ST_DRAIN_RD = 6'b001000,
    ST_DRAIN    = 6'b010000,
    ST_STATUS   = 6'b100000
  } ctl_state_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_START   = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_END     = 5'b01000,
    PH_PAD     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic emit_mosi;
    logic drain_rd;
    logic emit_rx;
    logic emit_status;
  } ctl_cmd_t;

  typedef struct packed {
    logic acc_mosi;
    logic acc_done;
    logic rx_empty;
    logic drain_last;
    logic slot_free;
  } dp_sts_t;

endpackage

// ===== sv/fsmt_if.sv =====
// valid/ready channel interfaces for transceiver input and result items
interface fsmt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] tx_byte;
  logic       line_mode;
  logic [7:0] miso_byte;

  modport source (output valid, output opcode, output tx_byte, output line_mode,
                  output miso_byte, input ready);
  modport sink   (input valid, input opcode, input tx_byte, input line_mode,
                  input miso_byte, output ready);
endinterface

interface fsmt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data;
  logic       last;
  logic       msg_seen;
  logic [3:0] rx_count;

  modport source (output valid, output kind, output data, output last,
                  output msg_seen, output rx_count, input ready);
  modport sink   (input valid, input kind, input data, input last,
                  input msg_seen, input rx_count, output ready);
endinterface

// ===== sv/framed_spi_message_transceiver.sv =====
// a load item is accepted in the wait state; a start or exchange item passes the fetch and emit states before
// its mosi byte is registered, and the block takes the next item once it is back in the wait state
// final exchange: each stored receive byte is read through the buffer read port and then emitted, then status
// throughput is set by the controller walk through fetch and emit, one item at a time
// synchronous active-low reset empties the payload, clears the frame and drops any result
module framed_spi_message_transceiver import fsmt_pkg::*; #(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  fsmt_in_if.sink      in_ch,
  fsmt_out_if.source   out_ch
);

  // command and status between sequencer and datapath
  ctl_cmd_t cmd;
  dp_sts_t  sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  // sequencer: accepts an item only when the previous one is fully handed off
  fsmt_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // datapath: frame position, filter, both buffers and the result register
  fsmt_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .opcode    (in_ch.opcode),
    .tx_byte   (in_ch.tx_byte),
    .line_mode (in_ch.line_mode),
    .miso_byte (in_ch.miso_byte),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_kind  (out_ch.kind),
    .out_data  (out_ch.data),
    .out_last  (out_ch.last),
    .out_msg   (out_ch.msg_seen),
    .out_cnt   (out_ch.rx_count)
  );

`ifndef SYNTHESIS
  // at most one result is loaded into the output register per cycle
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_mosi, cmd.emit_rx, cmd.emit_status}))
    else $error("more than one result loaded in a cycle");

  // a frame-ending exchange blocks new items while the receive drain and status run
  a_done_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && sts.acc_done) |=> !in_ch.ready)
    else $error("item accepted during receive drain");

  // status closes the item's result sequence
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_status |=> (out_ch.valid && out_ch.last && out_ch.kind == KIND_STATUS))
    else $error("status result not presented as last");

  // drained receive bytes never carry last
  a_rx_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_rx |=> (out_ch.valid && !out_ch.last && out_ch.kind == KIND_RX))
    else $error("received byte presented with wrong marking");
`endif

endmodule

// ===== sv/fsmt_ctl.sv =====
// sequencing state machine for item acceptance, byte fetch and receive drain
module fsmt_ctl import fsmt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dp_sts_t  sts,
  output logic     in_ready,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_WAIT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.acc_mosi) begin
            state_nxt = ST_FETCH;
          end else if (sts.acc_done) begin
            state_nxt = ST_DRAIN_RD;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit_mosi = 1'b1;
          state_nxt     = ST_WAIT;
        end
      end
      ST_DRAIN_RD: begin
        cmd.drain_rd = 1'b1;
        state_nxt    = sts.rx_empty ? ST_STATUS : ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.slot_free) begin
          cmd.emit_rx = 1'b1;
          state_nxt   = sts.drain_last ? ST_STATUS : ST_DRAIN_RD;
        end
      end
      ST_STATUS: begin
        if (sts.slot_free) begin
          cmd.emit_status = 1'b1;
          state_nxt       = ST_WAIT;
        end
      end
      default: begin
        state_nxt = ST_WAIT;
      end
    endcase
  end

endmodule

// ===== sv/fsmt_dp.sv =====
// frame state, payload and receive buffers, receive filter and result register
module fsmt_dp import fsmt_pkg::*; #(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_cmd_t            cmd,
  output dp_sts_t             sts,
  input  logic [1:0]          opcode,
  input  logic [7:0]          tx_byte,
  input  logic                line_mode,
  input  logic [7:0]          miso_byte,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_data,
  output logic                out_last,
  output logic                out_msg,
  output logic [RX_CNT_W-1:0] out_cnt
);

  localparam int LW  = $clog2(TX_DEPTH + 1);
  localparam int AW  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RXN = RX_DEPTH - 1;
  localparam int CW  = $clog2(RX_DEPTH);
  localparam int RIW = $clog2(RXN);
  localparam int PW  = $clog2(RX_DEPTH - 1);

  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RXN];
  logic [7:0] tx_q, rx_q;

  phase_t        phase_r, phase_nxt;
  logic [LW-1:0] len_r, len_nxt, pos_r, pos_nxt;
  logic [PW-1:0] pad_r, pad_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, didx_r, didx_nxt;
  logic          got_r, got_nxt, endsel_r, endsel_nxt;
  logic [7:0]    prev_r, prev_nxt, cur_r;

  logic                out_valid_r;
  logic [1:0]          kind_r;
  logic [7:0]          data_r;
  logic                last_r, msg_r;
  logic [RX_CNT_W-1:0] rxc_r;

  logic             idle, keep, xchg_done, do_load, do_rxwr, slot_free;
  logic [LW-1:0]    pos_inc;
  logic [SUM_W-1:0] len_p2, pad_calc, cnt_ext;
  logic [7:0]       mosi_byte;

  assign idle      = (phase_r == PH_IDLE);
  assign keep      = (miso_byte != 8'd0) && (miso_byte != prev_r) && (miso_byte != CH_GT);
  assign xchg_done = ((phase_r == PH_END) && (pad_r == '0)) ||
                     ((phase_r == PH_PAD) && (pad_r == PW'(1)));
  assign pos_inc   = pos_r + LW'(1);
  assign len_p2    = SUM_W'(len_r) + SUM_W'(2);
  assign pad_calc  = SUM_W'(RX_DEPTH) - len_p2;
  assign cnt_ext   = SUM_W'(cnt_r);
  assign slot_free = !out_valid_r || out_ready;

  assign do_load = cmd.accept && (opcode == OP_LOAD) && idle && (len_r < LW'(TX_DEPTH));
  assign do_rxwr = cmd.accept && (opcode == OP_XCHG) && !idle && keep && (cnt_r < CW'(RXN));

  assign sts.acc_mosi   = ((opcode == OP_START) && idle) ||
                          ((opcode == OP_XCHG) && !idle && !xchg_done);
  assign sts.acc_done   = (opcode == OP_XCHG) && !idle && xchg_done;
  assign sts.rx_empty   = (cnt_r == '0);
  assign sts.drain_last = ((didx_r + CW'(1)) == cnt_r);
  assign sts.slot_free  = slot_free;

  // byte driven on mosi for the exchange that follows
  always_comb begin
    case (phase_r)
      PH_START:   mosi_byte = CH_LT;
      PH_PAYLOAD: mosi_byte = tx_q;
      PH_END:     mosi_byte = endsel_r ? CH_AMP : CH_GT;
      default:    mosi_byte = 8'd0;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    pad_nxt    = pad_r;
    cnt_nxt    = cnt_r;
    got_nxt    = got_r;
    endsel_nxt = endsel_r;
    prev_nxt   = prev_r;
    didx_nxt   = didx_r;
    if (cmd.accept) begin
      case (opcode)
        OP_LOAD: begin
          if (do_load) begin
            len_nxt = len_r + LW'(1);
          end
        end
        OP_START: begin
          if (idle) begin
            endsel_nxt = line_mode;
            prev_nxt   = CH_AMP;
            cnt_nxt    = '0;
            got_nxt    = 1'b0;
            pos_nxt    = '0;
            pad_nxt    = (len_p2 <= SUM_W'(RX_DEPTH)) ? PW'(pad_calc) : '0;
            phase_nxt  = PH_START;
          end
        end
        OP_XCHG: begin
          if (!idle) begin
            if (keep) begin
              got_nxt = 1'b1;
              if (cnt_r < CW'(RXN)) begin
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            // padding keeps the end mark as filter reference
            if (phase_r != PH_PAD) begin
              prev_nxt = cur_r;
            end
            case (phase_r)
              PH_START: begin
                pos_nxt   = '0;
                phase_nxt = (len_r != '0) ? PH_PAYLOAD : PH_END;
              end
              PH_PAYLOAD: begin
                pos_nxt = pos_inc;
                if (pos_inc >= len_r) begin
                  phase_nxt = PH_END;
                end
              end
              PH_END: begin
                if (pad_r != '0) begin
                  phase_nxt = PH_PAD;
                end
              end
              PH_PAD: begin
                pad_nxt = pad_r - PW'(1);
              end
              default: begin
              end
            endcase
            if (xchg_done) begin
              phase_nxt = PH_IDLE;
              len_nxt   = '0;
              pos_nxt   = '0;
              pad_nxt   = '0;
              didx_nxt  = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.emit_rx) begin
      didx_nxt = didx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      len_r       <= '0;
      pos_r       <= '0;
      pad_r       <= '0;
      cnt_r       <= '0;
      got_r       <= 1'b0;
      endsel_r    <= 1'b0;
      prev_r      <= CH_AMP;
      didx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      pad_r    <= pad_nxt;
      cnt_r    <= cnt_nxt;
      got_r    <= got_nxt;
      endsel_r <= endsel_nxt;
      prev_r   <= prev_nxt;
      didx_r   <= didx_nxt;
      if (cmd.emit_mosi || cmd.emit_rx || cmd.emit_status) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // buffers, registered read
  always_ff @(posedge clk) begin
    if (do_load) begin
      tx_mem[len_r[AW-1:0]] <= tx_byte;
    end
    if (cmd.fetch) begin
      tx_q <= tx_mem[pos_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (do_rxwr) begin
      rx_mem[cnt_r[RIW-1:0]] <= miso_byte;
    end
    if (cmd.drain_rd) begin
      rx_q <= rx_mem[didx_r[RIW-1:0]];
    end
  end

  // result register and sent-byte tracker
  always_ff @(posedge clk) begin
    if (cmd.emit_mosi) begin
      cur_r  <= mosi_byte;
      kind_r <= KIND_MOSI;
      data_r <= mosi_byte;
      last_r <= 1'b1;
      msg_r  <= 1'b0;
      rxc_r  <= '0;
    end else if (cmd.emit_rx) begin
      kind_r <= KIND_RX;
      data_r <= rx_q;
      last_r <= 1'b0;
      msg_r  <= 1'b0;
      rxc_r  <= '0;
    end else if (cmd.emit_status) begin
      kind_r <= KIND_STATUS;
      data_r <= 8'd0;
      last_r <= 1'b1;
      msg_r  <= got_r;
      rxc_r  <= cnt_ext[RX_CNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_data  = data_r;
  assign out_last  = last_r;
  assign out_msg   = msg_r;
  assign out_cnt   = rxc_r;

endmodule
